FILE: src/md4_message_digest_top_macros.svh
// assertion macros shared by the md4 checker
`ifndef MD4_MESSAGE_DIGEST_TOP_MACROS_SVH
`define MD4_MESSAGE_DIGEST_TOP_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define MD4_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("md4 check failed");

// next-cycle implication, disabled while reset is asserted
`define MD4_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("md4 check failed");

`endif

FILE: src/md4_pkg.sv
// md4 package: request types, controller types, constants and round helpers
`timescale 1ns / 1ps

package md4_pkg;

	localparam logic [31:0] INIT_A = 32'h67452301;
	localparam logic [31:0] INIT_B = 32'hefcdab89;
	localparam logic [31:0] INIT_C = 32'h98badcfe;
	localparam logic [31:0] INIT_D = 32'h10325476;
	localparam logic [31:0] K_ROUND2 = 32'h5a827999;
	localparam logic [31:0] K_ROUND3 = 32'h6ed9eba1;
	localparam logic [7:0]  PAD_MARK = 8'h80;

	localparam int WORD_W     = 32;
	localparam int BLOCK_WORDS = 16;
	localparam int WADDR_W    = 4;

	localparam logic [5:0] LAST_POS  = 6'h3f;
	localparam logic [5:0] LEN_POS   = 6'd56;
	localparam logic [5:0] LAST_STEP = 6'd47;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_present;
		logic       end_of_message;
	} in_item_t;

	typedef struct packed {
		logic [63:0] digest_part;
		logic        final_part;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_LOAD,
		ST_COMP,
		ST_ADD,
		ST_OUT0,
		ST_OUT1
	} state_t;

	// commands from controller to datapath
	typedef struct packed {
		logic       byte_wr;
		logic       msg_byte;
		logic       pad_first;
		logic       len_block;
		logic       load_v;
		logic       step_en;
		logic [5:0] step;
		logic       add_chain;
		logic       out_hi;
		logic       restart;
	} dp_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic [5:0] pos;
	} dp_status_t;

	// message word used by a given step
	function automatic logic [3:0] word_idx(input logic [5:0] step);
		logic [3:0] k;
		logic [3:0] idx;
		k = step[3:0];
		case (step[5:4])
			2'd0: idx = k;
			2'd1: idx = {k[1:0], k[3:2]};
			default: idx = {k[0], k[1], k[2], k[3]};
		endcase
		return idx;
	endfunction

	// rotate amount of a given step
	function automatic logic [4:0] shift_amt(input logic [5:0] step);
		logic [4:0] s;
		case (step[5:4])
			2'd0: begin
				case (step[1:0])
					2'd0: s = 5'd3;
					2'd1: s = 5'd7;
					2'd2: s = 5'd11;
					default: s = 5'd19;
				endcase
			end
			2'd1: begin
				case (step[1:0])
					2'd0: s = 5'd3;
					2'd1: s = 5'd5;
					2'd2: s = 5'd9;
					default: s = 5'd13;
				endcase
			end
			default: begin
				case (step[1:0])
					2'd0: s = 5'd3;
					2'd1: s = 5'd9;
					2'd2: s = 5'd11;
					default: s = 5'd15;
				endcase
			end
		endcase
		return s;
	endfunction

	// additive constant of a given step
	function automatic logic [31:0] round_const(input logic [5:0] step);
		logic [31:0] kc;
		case (step[5:4])
			2'd0: kc = 32'h0;
			2'd1: kc = K_ROUND2;
			default: kc = K_ROUND3;
		endcase
		return kc;
	endfunction

endpackage

FILE: src/md4_ram.sv
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps

module md4_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rd_data <= mem_q[rd_addr];
	end

endmodule

FILE: src/md4_dp.sv
// md4 datapath: byte packing, block store, step unit, chaining values and counters
`timescale 1ns / 1ps

module md4_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  md4_pkg::dp_cmd_t   cmd,
	input  md4_pkg::in_item_t  in_data,
	output md4_pkg::dp_status_t status,
	output md4_pkg::out_item_t out_data
);

	logic [5:0]  pos_q;
	logic [60:0] byte_total_q;
	logic [23:0] acc_q;
	logic [3:0][31:0] chain_q;
	logic [31:0] va_q, vb_q, vc_q, vd_q;

	logic [63:0] bit_len;
	logic [7:0]  len_byte;
	logic [7:0]  pad_byte;
	logic [7:0]  wr_byte;
	logic        ram_we;
	logic [md4_pkg::WADDR_W-1:0] ram_waddr;
	logic [md4_pkg::WORD_W-1:0]  ram_wdata;
	logic [md4_pkg::WADDR_W-1:0] ram_raddr;
	logic [md4_pkg::WORD_W-1:0]  ram_rdata;
	logic [5:0]  next_step;
	logic [31:0] f_val;
	logic [31:0] sum;
	logic [31:0] rot;
	logic [4:0]  s_amt;

	// pad byte: marker, zero fill or length byte
	assign bit_len  = {byte_total_q, 3'b000};
	assign len_byte = bit_len[{pos_q[2:0], 3'b000} +: 8];
	always_comb begin
		if (cmd.pad_first) begin
			pad_byte = md4_pkg::PAD_MARK;
		end else if (cmd.len_block && (pos_q >= md4_pkg::LEN_POS)) begin
			pad_byte = len_byte;
		end else begin
			pad_byte = 8'h00;
		end
	end

	assign wr_byte   = cmd.msg_byte ? in_data.data_byte : pad_byte;
	assign ram_we    = cmd.byte_wr && (pos_q[1:0] == 2'd3);
	assign ram_waddr = pos_q[5:2];
	assign ram_wdata = {wr_byte, acc_q};

	// read address runs one step ahead of the step unit
	assign next_step = pos_q - pos_q + cmd.step + 6'd1;
	assign ram_raddr = cmd.load_v ? md4_pkg::word_idx(6'd0) : md4_pkg::word_idx(next_step);

	md4_ram #(
		.WIDTH(md4_pkg::WORD_W),
		.DEPTH(md4_pkg::BLOCK_WORDS)
	) u_block_ram (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (ram_waddr),
		.wr_data (ram_wdata),
		.rd_addr (ram_raddr),
		.rd_data (ram_rdata)
	);

	// little-endian word gathering
	always_ff @(posedge clk) begin
		if (cmd.byte_wr) begin
			acc_q <= {wr_byte, acc_q[23:8]};
		end
	end

	// block position and message byte count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q        <= '0;
			byte_total_q <= '0;
		end else if (cmd.restart) begin
			pos_q        <= '0;
			byte_total_q <= '0;
		end else if (cmd.byte_wr) begin
			pos_q <= pos_q + 6'd1;
			if (cmd.msg_byte) begin
				byte_total_q <= byte_total_q + 61'd1;
			end
		end
	end

	// round function and rotate
	always_comb begin
		case (cmd.step[5:4])
			2'd0: f_val = (vb_q & vc_q) | (~vb_q & vd_q);
			2'd1: f_val = (vb_q & vc_q) | (vb_q & vd_q) | (vc_q & vd_q);
			default: f_val = vb_q ^ vc_q ^ vd_q;
		endcase
	end
	assign s_amt = md4_pkg::shift_amt(cmd.step);
	assign sum   = va_q + f_val + ram_rdata + md4_pkg::round_const(cmd.step);
	assign rot   = (sum << s_amt) | (sum >> (6'd32 - {1'b0, s_amt}));

	// working variables, rotated one place each step
	always_ff @(posedge clk) begin
		if (cmd.load_v) begin
			va_q <= chain_q[0];
			vb_q <= chain_q[1];
			vc_q <= chain_q[2];
			vd_q <= chain_q[3];
		end else if (cmd.step_en) begin
			va_q <= vd_q;
			vb_q <= rot;
			vc_q <= vb_q;
			vd_q <= vc_q;
		end
	end

	// chaining values
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain_q <= {md4_pkg::INIT_D, md4_pkg::INIT_C, md4_pkg::INIT_B, md4_pkg::INIT_A};
		end else if (cmd.restart) begin
			chain_q <= {md4_pkg::INIT_D, md4_pkg::INIT_C, md4_pkg::INIT_B, md4_pkg::INIT_A};
		end else if (cmd.add_chain) begin
			chain_q[0] <= chain_q[0] + va_q;
			chain_q[1] <= chain_q[1] + vb_q;
			chain_q[2] <= chain_q[2] + vc_q;
			chain_q[3] <= chain_q[3] + vd_q;
		end
	end

	assign status.pos = pos_q;

	// digest halves
	assign out_data.digest_part = cmd.out_hi ? {chain_q[3], chain_q[2]}
	                                         : {chain_q[1], chain_q[0]};
	assign out_data.final_part  = cmd.out_hi;

endmodule

FILE: src/md4_ctrl.sv
// md4 controller: request intake, padding sequence, compression steps, digest output
`timescale 1ns / 1ps

module md4_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  md4_pkg::in_item_t   in_data,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  md4_pkg::dp_status_t status,
	output md4_pkg::dp_cmd_t    cmd
);

	md4_pkg::state_t state_q, state_d;
	logic [5:0] step_q;
	logic       eom_q;
	logic       pad_q;
	logic       len_block_q;
	logic       at_last;

	assign at_last = (status.pos == md4_pkg::LAST_POS);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			md4_pkg::ST_IDLE: begin
				if (in_valid) begin
					if (in_data.byte_present && at_last) begin
						state_d = md4_pkg::ST_LOAD;
					end else if (in_data.end_of_message) begin
						state_d = md4_pkg::ST_PAD;
					end
				end
			end
			md4_pkg::ST_PAD: begin
				if (at_last) begin
					state_d = md4_pkg::ST_LOAD;
				end
			end
			md4_pkg::ST_LOAD: state_d = md4_pkg::ST_COMP;
			md4_pkg::ST_COMP: begin
				if (step_q == md4_pkg::LAST_STEP) begin
					state_d = md4_pkg::ST_ADD;
				end
			end
			md4_pkg::ST_ADD: begin
				if (pad_q) begin
					state_d = len_block_q ? md4_pkg::ST_OUT0 : md4_pkg::ST_PAD;
				end else if (eom_q) begin
					state_d = md4_pkg::ST_PAD;
				end else begin
					state_d = md4_pkg::ST_IDLE;
				end
			end
			md4_pkg::ST_OUT0: begin
				if (out_ready) begin
					state_d = md4_pkg::ST_OUT1;
				end
			end
			md4_pkg::ST_OUT1: begin
				if (out_ready) begin
					state_d = md4_pkg::ST_IDLE;
				end
			end
			default: state_d = md4_pkg::ST_IDLE;
		endcase
	end

	// outputs and datapath commands
	always_comb begin
		in_ready  = 1'b0;
		out_valid = 1'b0;
		cmd       = '0;
		cmd.step  = step_q;
		cmd.len_block = len_block_q;
		case (state_q)
			md4_pkg::ST_IDLE: begin
				in_ready     = 1'b1;
				cmd.byte_wr  = in_valid && in_data.byte_present;
				cmd.msg_byte = 1'b1;
			end
			md4_pkg::ST_PAD: begin
				cmd.byte_wr   = 1'b1;
				cmd.pad_first = !pad_q;
			end
			md4_pkg::ST_LOAD: cmd.load_v = 1'b1;
			md4_pkg::ST_COMP: cmd.step_en = 1'b1;
			md4_pkg::ST_ADD:  cmd.add_chain = 1'b1;
			md4_pkg::ST_OUT0: out_valid = 1'b1;
			md4_pkg::ST_OUT1: begin
				out_valid   = 1'b1;
				cmd.out_hi  = 1'b1;
				cmd.restart = out_ready;
			end
			default: ;
		endcase
	end

	// state and sequencing registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= md4_pkg::ST_IDLE;
			step_q      <= '0;
			eom_q       <= 1'b0;
			pad_q       <= 1'b0;
			len_block_q <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				md4_pkg::ST_IDLE: begin
					if (in_valid) begin
						eom_q <= in_data.end_of_message;
						pad_q <= 1'b0;
					end
				end
				md4_pkg::ST_PAD: begin
					pad_q <= 1'b1;
					// the length fits in this block only if the marker lands before it
					if (!pad_q) begin
						len_block_q <= (status.pos < md4_pkg::LEN_POS);
					end
				end
				md4_pkg::ST_LOAD: step_q <= '0;
				md4_pkg::ST_COMP: step_q <= step_q + 6'd1;
				md4_pkg::ST_ADD: begin
					if (pad_q && !len_block_q) begin
						len_block_q <= 1'b1;
					end
				end
				md4_pkg::ST_OUT1: begin
					if (out_ready) begin
						eom_q <= 1'b0;
						pad_q <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

endmodule

FILE: src/md4_message_digest_top.sv
// md4 message digest top level: controller and datapath
//
//   channel | dir | handshake           | payload
//   in      | in  | in_valid / in_ready  | in_data (byte, present, end)
//   out     | out | out_valid/ out_ready | out_data (64-bit half, final flag)
//
// a message byte is taken on each handshake; each full 64-byte block then
// runs a word fetch, 48 steps of the shared step unit and a chain update.
// end of message: one pad byte a cycle up to the block end, one or two
// compressions, then two output requests (bytes 0..7, then 8..15).
// reset returns the chaining values and byte count to their initial values.
// no request is taken while a block compresses or the digest waits.
`timescale 1ns / 1ps

module md4_message_digest_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  md4_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output md4_pkg::out_item_t out_data
);

	md4_pkg::dp_cmd_t    cmd;
	md4_pkg::dp_status_t status;

	// sequencing
	md4_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_data   (in_data),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	// storage and arithmetic
	md4_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.in_data  (in_data),
		.status   (status),
		.out_data (out_data)
	);

endmodule

FILE: src/md4_checker.sv
// md4 port checker and its bind to the top level
`timescale 1ns / 1ps
`include "md4_message_digest_top_macros.svh"

module md4_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input md4_pkg::in_item_t  in_data,
	input logic               out_valid,
	input logic               out_ready,
	input md4_pkg::out_item_t out_data
);

	// a stalled result holds
	`MD4_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_data))

	// no request is taken while the digest is being delivered
	`MD4_ASSERT_NOW(a_no_in_during_out, clk, arst_n, out_valid, !in_ready)

	// second digest half follows the first at once
	`MD4_ASSERT_NEXT(a_second_half, clk, arst_n, out_valid && out_ready && !out_data.final_part, out_valid && out_data.final_part)

	// end of message starts padding, so intake closes
	`MD4_ASSERT_NEXT(a_end_closes, clk, arst_n, in_valid && in_ready && in_data.end_of_message, !in_ready)

endmodule

bind md4_message_digest_top md4_checker u_md4_checker (.*);

FILE: tb/tb_md4_message_digest_top.sv
// self-checking testbench for the md4 message digest block
`timescale 1ns / 1ps

module tb_md4_message_digest_top;

	localparam int CYCLE_LIMIT = 400000;
	localparam int BYTE_ITEMS  = 700;
	localparam int TAIL_CYCLES = 120;

	localparam logic [31:0] IV_A = 32'h67452301;
	localparam logic [31:0] IV_B = 32'hefcdab89;
	localparam logic [31:0] IV_C = 32'h98badcfe;
	localparam logic [31:0] IV_D = 32'h10325476;
	localparam logic [31:0] ADD_R2 = 32'h5a827999;
	localparam logic [31:0] ADD_R3 = 32'h6ed9eba1;
	localparam logic [7:0]  PAD_BYTE = 8'h80;

	typedef struct {
		md4_pkg::in_item_t req;
		bit                drain_first;
	} queued_req_t;

	logic               clk;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	md4_pkg::in_item_t  in_data = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	md4_pkg::out_item_t out_data;

	// hash state tracked alongside the block
	logic [31:0] chain_st [4];
	logic [7:0]  blk_st [64];
	logic [60:0] total_st;

	queued_req_t        pending_reqs [$];
	md4_pkg::out_item_t digests_due [$];

	bit stim_go = 1'b0;
	bit in_took = 1'b0;
	int burst_left = 0;
	int gap_left = 0;
	int ready_mode = 0;
	int mode_left = 0;
	int ready_tick = 0;
	int cycle_count = 0;
	int mismatch_count = 0;
	int reqs_taken = 0;
	int bytes_taken = 0;
	int halves_checked = 0;
	int messages_done = 0;
	int byte_items_queued = 0;

	md4_message_digest_top u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [31:0] rol32(input logic [31:0] v, input int s);
		return (v << s) | (v >> (32 - s));
	endfunction

	// rotate amount per step, by round and column
	function automatic int step_shift(input int j);
		int col;
		int rnd;
		col = j % 4;
		rnd = j / 16;
		if (col == 0)
			return 3;
		if (rnd == 0)
			return (col == 1) ? 7 : (col == 2) ? 11 : 19;
		if (rnd == 1)
			return (col == 1) ? 5 : (col == 2) ? 9 : 13;
		return (col == 1) ? 9 : (col == 2) ? 11 : 15;
	endfunction

	// one 48-step compression of the gathered block into the chain
	function automatic void compress_block();
		logic [31:0] m [16];
		logic [31:0] v [4];
		logic [31:0] p, q, r, f, w;
		int t, k, idx, j;
		for (j = 0; j < 16; j++)
			m[j] = {blk_st[4*j+3], blk_st[4*j+2], blk_st[4*j+1], blk_st[4*j]};
		for (j = 0; j < 4; j++)
			v[j] = chain_st[j];
		for (j = 0; j < 48; j++) begin
			t = (4 - (j % 4)) % 4;
			p = v[(t + 1) % 4];
			q = v[(t + 2) % 4];
			r = v[(t + 3) % 4];
			k = j % 16;
			if (j < 16) begin
				f = (p & q) | (~p & r);
				w = m[k];
			end else if (j < 32) begin
				idx = (k % 4) * 4 + k / 4;
				f = (p & q) | (p & r) | (q & r);
				w = m[idx] + ADD_R2;
			end else begin
				idx = ((k & 1) << 3) | ((k & 2) << 1) | ((k & 4) >> 1) | ((k & 8) >> 3);
				f = p ^ q ^ r;
				w = m[idx] + ADD_R3;
			end
			v[t] = rol32(v[t] + f + w, step_shift(j));
		end
		for (j = 0; j < 4; j++)
			chain_st[j] = chain_st[j] + v[j];
	endfunction

	function automatic void restart_hash();
		chain_st[0] = IV_A;
		chain_st[1] = IV_B;
		chain_st[2] = IV_C;
		chain_st[3] = IV_D;
		total_st = '0;
	endfunction

	// absorb one accepted request; on end of message queue both digest halves
	function automatic void absorb_request(input md4_pkg::in_item_t req);
		int pos;
		int used;
		int j;
		logic [63:0] bit_len;
		md4_pkg::out_item_t half;
		if (req.byte_present) begin
			pos = int'(total_st[5:0]);
			blk_st[pos] = req.data_byte;
			total_st = total_st + 61'd1;
			if (pos == 63)
				compress_block();
		end
		if (req.end_of_message) begin
			used = int'(total_st[5:0]);
			bit_len = {total_st, 3'b000};
			blk_st[used] = PAD_BYTE;
			used++;
			// no room left for the length: close this block first
			if (used > 56) begin
				for (; used < 64; used++)
					blk_st[used] = 8'h00;
				compress_block();
				used = 0;
			end
			for (; used < 56; used++)
				blk_st[used] = 8'h00;
			for (j = 0; j < 8; j++)
				blk_st[56 + j] = bit_len[8*j +: 8];
			compress_block();
			half.digest_part = {chain_st[1], chain_st[0]};
			half.final_part = 1'b0;
			digests_due.push_back(half);
			half.digest_part = {chain_st[3], chain_st[2]};
			half.final_part = 1'b1;
			digests_due.push_back(half);
			restart_hash();
		end
	endfunction

	function automatic void note_failure(input string msg);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("mismatch at cycle %0d: %s", cycle_count, msg);
	endfunction

	// compare one received digest half with the oldest one due
	function automatic void check_digest(input md4_pkg::out_item_t got);
		md4_pkg::out_item_t want;
		if (digests_due.size() == 0) begin
			note_failure($sformatf("digest half %h final %0b with none due",
				got.digest_part, got.final_part));
		end else begin
			want = digests_due.pop_front();
			if (got.digest_part !== want.digest_part)
				note_failure($sformatf("digest_part expected %h got %h",
					want.digest_part, got.digest_part));
			if (got.final_part !== want.final_part)
				note_failure($sformatf("final_part expected %0b got %0b",
					want.final_part, got.final_part));
			halves_checked++;
			if (want.final_part)
				messages_done++;
		end
	endfunction

	function automatic void queue_req(input logic [7:0] b, input bit present, input bit eom,
		input bit drain);
		queued_req_t item;
		item.req.data_byte = b;
		item.req.byte_present = present;
		item.req.end_of_message = eom;
		item.drain_first = drain;
		pending_reqs.push_back(item);
		if (present || eom)
			byte_items_queued++;
	endfunction

	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 7))
			0: return 8'h00;
			1: return 8'hff;
			default: return 8'($urandom);
		endcase
	endfunction

	// one message of msg_len bytes with random content, idle requests mixed in
	function automatic void queue_message(input int msg_len, input bit drain);
		int i;
		bit end_on_byte;
		bit first;
		end_on_byte = (msg_len > 0) && ($urandom_range(0, 1) == 1);
		first = drain;
		for (i = 0; i < msg_len; i++) begin
			if ($urandom_range(0, 19) == 0) begin
				queue_req(8'($urandom), 1'b0, 1'b0, first);
				first = 1'b0;
			end
			queue_req(pick_byte(), 1'b1, end_on_byte && (i == msg_len - 1), first);
			first = 1'b0;
		end
		if (!end_on_byte)
			queue_req(8'($urandom), 1'b0, 1'b1, first);
	endfunction

	function automatic int pick_length();
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: return $urandom_range(0, 20);
			5, 6: return $urandom_range(50, 72);
			7: return $urandom_range(112, 136);
			8: begin
				case ($urandom_range(0, 6))
					0: return 55;
					1: return 56;
					2: return 57;
					3: return 63;
					4: return 64;
					5: return 119;
					default: return 120;
				endcase
			end
			default: return $urandom_range(0, 200);
		endcase
	endfunction

	// sender: bursts of requests separated by random gaps
	always @(negedge clk) begin
		if (!arst_n || !stim_go) begin
			in_valid <= 1'b0;
		end else if (in_valid && !in_took) begin
			in_valid <= 1'b1;
		end else if (gap_left > 0) begin
			gap_left <= gap_left - 1;
			in_valid <= 1'b0;
		end else if (pending_reqs.size() == 0) begin
			in_valid <= 1'b0;
		end else if (pending_reqs[0].drain_first && digests_due.size() != 0) begin
			// hold off until every digest due has come back
			in_valid <= 1'b0;
		end else begin
			in_data <= pending_reqs[0].req;
			in_valid <= 1'b1;
			void'(pending_reqs.pop_front());
			if (burst_left <= 1) begin
				burst_left <= $urandom_range(1, 24);
				gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			end else begin
				burst_left <= burst_left - 1;
			end
		end
	end

	// receiver: stall pattern switches between modes
	always @(negedge clk) begin
		if (mode_left <= 0) begin
			ready_mode <= $urandom_range(0, 3);
			mode_left <= $urandom_range(16, 64);
		end else begin
			mode_left <= mode_left - 1;
		end
		ready_tick <= ready_tick + 1;
		case (ready_mode)
			0: out_ready <= 1'b1;
			1: out_ready <= 1'($urandom_range(0, 1));
			2: out_ready <= (ready_tick % 4 == 0);
			default: out_ready <= (ready_tick % 9 > 5);
		endcase
	end

	// sample handshakes, predict and check
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d halves still due",
				cycle_count, digests_due.size());
			$display("TB_ERROR");
			$finish;
		end else if (!arst_n) begin
			in_took <= 1'b0;
		end else begin
			in_took <= in_valid && in_ready;
			if (out_valid && out_ready)
				check_digest(out_data);
			if (in_valid && in_ready) begin
				absorb_request(in_data);
				reqs_taken++;
				if (in_data.byte_present)
					bytes_taken++;
			end
		end
	end

	// stimulus, reset and end of run
	initial begin
		int msg_idx;
		int j;
		restart_hash();
		for (j = 0; j < 64; j++)
			blk_st[j] = 8'h00;

		// directed: empty message, idle request, single extreme bytes, short text
		queue_req(8'hff, 1'b0, 1'b1, 1'b0);
		queue_req(8'h5a, 1'b0, 1'b0, 1'b0);
		queue_req(8'hff, 1'b1, 1'b1, 1'b0);
		queue_req(8'h00, 1'b1, 1'b1, 1'b0);
		queue_req(8'h00, 1'b1, 1'b0, 1'b0);
		queue_req(8'hff, 1'b0, 1'b1, 1'b0);
		queue_req(8'h61, 1'b1, 1'b0, 1'b0);
		queue_req(8'h00, 1'b0, 1'b0, 1'b0);
		queue_req(8'h62, 1'b1, 1'b0, 1'b0);
		queue_req(8'h63, 1'b1, 1'b1, 1'b0);

		// random messages, every fourth one after a full drain
		msg_idx = 0;
		while (byte_items_queued < BYTE_ITEMS) begin
			queue_message(pick_length(), (msg_idx % 4) == 0);
			msg_idx++;
		end

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(posedge clk);
		stim_go = 1'b1;

		// poll until every request is sent and every digest half is back
		while (pending_reqs.size() != 0 || in_valid)
			@(posedge clk);
		while (digests_due.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("covered %0d requests (%0d message bytes) over %0d messages",
			reqs_taken, bytes_taken, messages_done);
		$display("%0d digest halves compared, %0d mismatches", halves_checked, mismatch_count);
		if (mismatch_count == 0 && digests_due.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
